// ===== rtl/ftci_pkg.sv =====
// Shared types, constants and helper functions for the collision interlock.
package ftci_pkg;

   localparam int GRID_SIDE   = 16;
   localparam int GRID_STEP   = 128;
   localparam int MAX_PASSES  = 8;
   localparam int CELL_BITS   = $clog2(GRID_SIDE);
   localparam int ADDR_BITS   = 2 * CELL_BITS;
   localparam int TABLE_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int STEP_SHIFT  = $clog2(GRID_STEP);
   localparam int PASS_BITS   = $clog2(MAX_PASSES + 1);

   localparam logic [11:0] ANGLE_CLOSED = 12'd890;
   localparam logic [11:0] ANGLE_OPEN   = 12'd1850;
   localparam logic [9:0]  ANGLE_SPAN   = 10'd960;
   localparam logic [10:0] TARGET_MAX   = 11'd2000;
   localparam logic [11:0] NO_TARGET    = 12'hFFF;

   // Angle scaling is span * 25 / 12: a shift by two, then a reciprocal of three.
   localparam logic [14:0] SCALE_MUL   = 15'd25;
   localparam logic [16:0] THIRD_RECIP = 17'd43691;
   localparam int          THIRD_SHIFT = 17;

   localparam logic [10:0] CLASH_RESET = 11'd600;
   localparam logic [10:0] BLOCK_RESET = 11'd800;
   localparam logic [10:0] SAFE_RESET  = 11'd1200;

   localparam logic [1:0] MODE_CHECK = 2'd0;
   localparam logic [1:0] MODE_BEND  = 2'd1;
   localparam logic [1:0] MODE_ROT   = 2'd2;

   localparam logic [1:0] REG_CLASH = 2'd0;
   localparam logic [1:0] REG_BLOCK = 2'd1;
   localparam logic [1:0] REG_SAFE  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_RULES, ST_BADDR, ST_BRD0, ST_BRD1, ST_BRD2, ST_BRD3,
      ST_BUPD, ST_RADDR, ST_RRD0, ST_RRD1, ST_RRD2, ST_RRD3, ST_RUPD, ST_DONE
   } state_type;

   // Controller commands to the datapath.
   typedef struct packed {
      logic       load;
      logic       prep;
      logic       rules;
      logic       bend_addr;
      logic       rot_addr;
      logic [1:0] corner;
      logic       rd_en;
      logic       bend_sel;
      logic       grab;
      logic       bend_upd;
      logic       rot_upd;
      logic       done;
   } cmd_type;

   typedef struct packed {
      logic changed;
   } status_type;

   // Clamp a signed 16-bit target; all ones means no command.
   function automatic logic [11:0] clamp_target(input logic [15:0] t);
      logic [11:0] r;
      if (t == 16'hFFFF) r = NO_TARGET;
      else if (t[15]) r = 12'd0;
      else if (t > {5'd0, TARGET_MAX}) r = {1'b0, TARGET_MAX};
      else r = t[11:0];
      return r;
   endfunction

   // Clamp a grid coordinate cell index.
   function automatic logic [CELL_BITS-1:0] cell_of(input logic [10:0] v);
      logic [10:0] c;
      c = v >> STEP_SHIFT;
      if (c > 11'(GRID_SIDE - 1)) c = 11'(GRID_SIDE - 1);
      return c[CELL_BITS-1:0];
   endfunction

endpackage

// ===== rtl/ftci_ram.sv =====
// Generic single-port-write, registered-read RAM.
module ftci_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== rtl/ftci_angle_map.sv =====
// Angle mapper scaling a raw angle onto the 0..2000 scale, registering the product and then the result.
module ftci_angle_map (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [11:0] angle,
   output logic        busy,
   output logic [10:0] scaled
);
   import ftci_pkg::*;

   logic [14:0] prod_ff, prod_in;
   logic [10:0] scaled_ff, scaled_in;
   logic        busy_ff, busy_in;
   logic [9:0]  span;
   logic [12:0] quarter;
   logic [29:0] recip;

   // First step: limit the span above the closed angle and multiply by 25.
   always_comb begin
      if (angle <= ANGLE_CLOSED) span = '0;
      else if (angle >= ANGLE_OPEN) span = ANGLE_SPAN;
      else span = 10'(angle - ANGLE_CLOSED);
      prod_in = start ? 15'(span) * SCALE_MUL : prod_ff;
      busy_in = start;
   end

   // Second step: divide by 12 as a shift by two and a reciprocal of three.
   always_comb begin
      quarter   = prod_ff[14:2];
      recip     = 30'(quarter) * 30'(THIRD_RECIP);
      scaled_in = busy_ff ? recip[THIRD_SHIFT+10:THIRD_SHIFT] : scaled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      prod_ff   <= prod_in;
      scaled_ff <= scaled_in;
   end

   assign busy   = busy_ff;
   assign scaled = scaled_ff;
endmodule

// ===== rtl/ftci_ctrl.sv =====
// Controller state machine sequencing rules and grid passes.
module ftci_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_mode,
   input  logic                 map_busy,
   input  ftci_pkg::status_type status,
   output ftci_pkg::cmd_type    cmd,
   output logic                 busy
);
   import ftci_pkg::*;

   state_type state_ff, state_in;
   logic [PASS_BITS-1:0] pass_ff, pass_in;
   logic                 chg_ff, chg_in;
   logic                 map_wait_ff, map_wait_in;

   // Next state.
   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      chg_in      = chg_ff;
      map_wait_in = map_wait_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode == MODE_CHECK) begin
                  state_in    = ST_PREP;
                  map_wait_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_PREP: begin
            map_wait_in = 1'b0;
            if (!map_wait_ff && !map_busy) state_in = ST_RULES;
         end
         ST_RULES: begin
            pass_in  = '0;
            state_in = ST_BADDR;
         end
         ST_BADDR: begin
            chg_in   = 1'b0;
            state_in = ST_BRD0;
         end
         ST_BRD0: state_in = ST_BRD1;
         ST_BRD1: state_in = ST_BRD2;
         ST_BRD2: state_in = ST_BRD3;
         ST_BRD3: state_in = ST_BUPD;
         ST_BUPD: begin
            chg_in   = status.changed;
            state_in = ST_RADDR;
         end
         ST_RADDR: state_in = ST_RRD0;
         ST_RRD0:  state_in = ST_RRD1;
         ST_RRD1:  state_in = ST_RRD2;
         ST_RRD2:  state_in = ST_RRD3;
         ST_RRD3:  state_in = ST_RUPD;
         ST_RUPD: begin
            pass_in = pass_ff + PASS_BITS'(1);
            if ((chg_ff || status.changed) && (pass_ff != PASS_BITS'(MAX_PASSES - 1)))
               state_in = ST_BADDR;
            else
               state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs. Each read state fetches one corner; the last corner is merged at update.
   always_comb begin
      cmd       = '0;
      cmd.load  = (state_ff == ST_IDLE) && start && (req_mode != MODE_CHECK);
      cmd.prep  = (state_ff == ST_IDLE) && start && (req_mode == MODE_CHECK);
      case (state_ff)
         ST_RULES: cmd.rules = 1'b1;
         ST_BADDR: cmd.bend_addr = 1'b1;
         ST_BRD0, ST_BRD1, ST_BRD2, ST_BRD3: begin
            cmd.rd_en    = 1'b1;
            cmd.bend_sel = 1'b1;
            cmd.corner   = 2'(state_ff - ST_BRD0);
            cmd.grab     = (state_ff != ST_BRD0);
         end
         ST_BUPD: begin
            cmd.grab     = 1'b1;
            cmd.bend_upd = 1'b1;
         end
         ST_RADDR: cmd.rot_addr = 1'b1;
         ST_RRD0, ST_RRD1, ST_RRD2, ST_RRD3: begin
            cmd.rd_en  = 1'b1;
            cmd.corner = 2'(state_ff - ST_RRD0);
            cmd.grab   = (state_ff != ST_RRD0);
         end
         ST_RUPD: begin
            cmd.grab    = 1'b1;
            cmd.rot_upd = 1'b1;
         end
         ST_DONE: cmd.done = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pass_ff     <= '0;
         chg_ff      <= 1'b0;
         map_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         chg_ff      <= chg_in;
         map_wait_ff <= map_wait_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> !cmd.done) else $error("done repeated");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> (state_ff != ST_PREP) || $past(state_ff == ST_IDLE) || $past(state_ff == ST_PREP))
      else $error("prep entered while busy");
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      pass_ff <= PASS_BITS'(MAX_PASSES)) else $error("pass count overrun");
`endif
endmodule

// ===== rtl/ftci_dpath.sv =====
// Datapath: clamping, angle mapping, scalar rules, grid table lookup.
module ftci_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  ftci_pkg::cmd_type     cmd,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_table_addr,
   input  logic [11:0]           req_table_value,
   input  logic [15:0]           req_index_target,
   input  logic [15:0]           req_middle_target,
   input  logic [15:0]           req_bend_target,
   input  logic [15:0]           req_rot_target,
   input  logic [11:0]           req_index_angle,
   input  logic [11:0]           req_middle_angle,
   input  logic [11:0]           req_bend_angle,
   input  logic [11:0]           req_rot_angle,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [10:0]           csr_data,
   output logic                  map_busy,
   output ftci_pkg::status_type  status,
   output logic                  rsp_valid,
   output logic [11:0]           rsp_index_out,
   output logic [11:0]           rsp_middle_out,
   output logic [11:0]           rsp_bend_out,
   output logic [11:0]           rsp_rot_out,
   output logic [4:0]            rsp_fix_count
);
   import ftci_pkg::*;

   logic [10:0] clash_ff, block_ff, safe_ff, csr_sat;
   logic [11:0] ti_ff, tm_ff, tb_ff, tr_ff;
   logic [10:0] ai, am, ab, ar;
   logic [3:0]  mbusy;
   logic [4:0]  fix_ff, fix_in;
   logic [10:0] idx, md, thb, rot, f_val, col_val;
   logic [CELL_BITS-1:0] r0_ff, c0_ff, r1_ff, c1_ff;
   logic [CELL_BITS-1:0] rr, cc;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [11:0] bend_rd, rot_rd, rd_val, max_ff, max_all, want;
   logic        bend_wr, rot_wr;
   logic        first_ff;
   logic [1:0]  req_mode_ff;

   // Configuration registers, saturated to the target range.
   assign csr_sat = (csr_data > TARGET_MAX) ? TARGET_MAX : csr_data;
   always_ff @(posedge clock) begin
      if (reset) begin
         clash_ff <= CLASH_RESET;
         block_ff <= BLOCK_RESET;
         safe_ff  <= SAFE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CLASH: clash_ff <= csr_sat;
            REG_BLOCK: block_ff <= csr_sat;
            REG_SAFE:  safe_ff  <= csr_sat;
            default: ;
         endcase
      end
   end

   // Four angle mappers working in parallel.
   ftci_angle_map u_map_i (.clock, .reset, .start(cmd.prep), .angle(req_index_angle),
                           .busy(mbusy[0]), .scaled(ai));
   ftci_angle_map u_map_m (.clock, .reset, .start(cmd.prep), .angle(req_middle_angle),
                           .busy(mbusy[1]), .scaled(am));
   ftci_angle_map u_map_b (.clock, .reset, .start(cmd.prep), .angle(req_bend_angle),
                           .busy(mbusy[2]), .scaled(ab));
   ftci_angle_map u_map_r (.clock, .reset, .start(cmd.prep), .angle(req_rot_angle),
                           .busy(mbusy[3]), .scaled(ar));
   assign map_busy = |mbusy;

   // Effective values: the target if given, else the mapped angle.
   assign idx   = (ti_ff == NO_TARGET) ? ai : ti_ff[10:0];
   assign md    = (tm_ff == NO_TARGET) ? am : tm_ff[10:0];
   assign thb   = (tb_ff == NO_TARGET) ? ab : tb_ff[10:0];
   assign rot   = (tr_ff == NO_TARGET) ? ar : tr_ff[10:0];
   assign f_val = (idx < md) ? idx : md;
   assign col_val = cmd.bend_addr ? rot : thb;

   // Table stores.
   assign bend_wr = cmd.load && (req_mode == MODE_BEND);
   assign rot_wr  = cmd.load && (req_mode == MODE_ROT);

   always_comb begin
      case (cmd.corner)
         2'd0: begin rr = r0_ff; cc = c0_ff; end
         2'd1: begin rr = r0_ff; cc = c1_ff; end
         2'd2: begin rr = r1_ff; cc = c0_ff; end
         default: begin rr = r1_ff; cc = c1_ff; end
      endcase
   end
   assign rd_addr = {rr, cc};

   ftci_ram #(.WIDTH(12), .DEPTH(TABLE_CELLS)) u_bend_ram (
      .clock, .wr_en(bend_wr), .wr_addr(req_table_addr[ADDR_BITS-1:0]),
      .wr_data(req_table_value), .rd_en(cmd.rd_en && cmd.bend_sel),
      .rd_addr, .rd_data(bend_rd));
   ftci_ram #(.WIDTH(12), .DEPTH(TABLE_CELLS)) u_rot_ram (
      .clock, .wr_en(rot_wr), .wr_addr(req_table_addr[ADDR_BITS-1:0]),
      .wr_data(req_table_value), .rd_en(cmd.rd_en && !cmd.bend_sel),
      .rd_addr, .rd_data(rot_rd));

   // The update cycle merges the last corner, still on the read port, into the maximum.
   assign rd_val  = cmd.bend_upd || (cmd.grab && cmd.bend_sel) ? bend_rd : rot_rd;
   assign max_all = (rd_val > max_ff) ? rd_val : max_ff;
   assign want    = (max_all > {1'b0, TARGET_MAX}) ? {1'b0, TARGET_MAX} : max_all;
   assign status.changed = (cmd.bend_upd && ({1'b0, thb} < want)) ||
                           (cmd.rot_upd && ({1'b0, rot} < want));

   // Fix counter, saturating.
   always_comb begin
      fix_in = fix_ff;
      if (cmd.prep) fix_in = '0;
      else if (cmd.rules)
         fix_in = fix_ff + 5'(((idx < clash_ff) && (thb < clash_ff)) ? 1 : 0)
                         + 5'(((idx < block_ff) && (rot < safe_ff)) ? 1 : 0);
      else if (status.changed && fix_ff != 5'd31) fix_in = fix_ff + 5'd1;
   end

   // Working targets, cell coordinates and running maximum.
   always_ff @(posedge clock) begin
      fix_ff <= fix_in;
      if (cmd.prep) begin
         ti_ff <= clamp_target(req_index_target);
         tm_ff <= clamp_target(req_middle_target);
         tb_ff <= clamp_target(req_bend_target);
         tr_ff <= clamp_target(req_rot_target);
      end else if (cmd.rules) begin
         if ((idx < clash_ff) && (thb < clash_ff)) tb_ff <= {1'b0, clash_ff};
         if ((idx < block_ff) && (rot < safe_ff))  tr_ff <= {1'b0, safe_ff};
      end else if (cmd.bend_upd) begin
         if ({1'b0, thb} < want) tb_ff <= want;
      end else if (cmd.rot_upd) begin
         if ({1'b0, rot} < want) tr_ff <= want;
      end
      if (cmd.bend_addr || cmd.rot_addr) begin
         r0_ff    <= cell_of(f_val);
         c0_ff    <= cell_of(col_val);
         r1_ff    <= (cell_of(f_val) == CELL_BITS'(GRID_SIDE - 1)) ? cell_of(f_val)
                     : cell_of(f_val) + CELL_BITS'(1);
         c1_ff    <= (cell_of(col_val) == CELL_BITS'(GRID_SIDE - 1)) ? cell_of(col_val)
                     : cell_of(col_val) + CELL_BITS'(1);
         first_ff <= 1'b1;
      end else if (cmd.grab) begin
         first_ff <= 1'b0;
         if (first_ff || rd_val > max_ff) max_ff <= rd_val;
      end
   end

   // Result register, shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= cmd.done;
      if (cmd.done) begin
         rsp_index_out  <= (req_mode_ff == MODE_CHECK) ? ti_ff : NO_TARGET;
         rsp_middle_out <= (req_mode_ff == MODE_CHECK) ? tm_ff : NO_TARGET;
         rsp_bend_out   <= (req_mode_ff == MODE_CHECK) ? tb_ff : NO_TARGET;
         rsp_rot_out    <= (req_mode_ff == MODE_CHECK) ? tr_ff : NO_TARGET;
         rsp_fix_count  <= (req_mode_ff == MODE_CHECK) ? fix_ff : 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.prep) req_mode_ff <= req_mode;
   end

`ifndef SYNTHESIS
   a_want_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.bend_upd |-> want <= 12'(TARGET_MAX)) else $error("cap lost");
   a_cfg_range: assert property (@(posedge clock) disable iff (reset)
      clash_ff <= TARGET_MAX && safe_ff <= TARGET_MAX) else $error("cfg range");
   a_fix_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !status.changed) else $error("load changed targets");
`endif
endmodule

// ===== rtl/finger_thumb_collision_interlock_top.sv =====
// Top level of the finger/thumb collision interlock.
// Requests enter on start with the req_ fields; start is taken when busy is low.
// Mode 0 checks targets, modes 1 and 2 write one entry of the bend or rotation
// minimum table. Every request gives one result on the rsp_ ports, marked by
// rsp_valid for exactly one cycle; the receiver cannot stall it.
// A load request keeps busy high for one cycle, in the done state, and its
// result is registered from that state; a new request can be taken as it shows.
// A check request waits in the prep state for the four parallel angle mappers,
// applies the scalar rules in the rules state, then runs 1 to 8 grid passes
// (four corner reads from each table plus address and update steps) and ends
// in the done state; busy stays high through the done state and the result is
// registered from it, so a new check can be taken only once busy is low again.
// Registers are written on the csr_ channel (csr_ready is always high); the user
// must write them only while the block is idle; the block does not enforce this.
// Reset restores the register defaults and returns the controller to idle;
// table contents stay undefined until loaded.
module finger_thumb_collision_interlock_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_table_addr,
   input  logic [11:0] req_table_value,
   input  logic [15:0] req_index_target,
   input  logic [15:0] req_middle_target,
   input  logic [15:0] req_bend_target,
   input  logic [15:0] req_rot_target,
   input  logic [11:0] req_index_angle,
   input  logic [11:0] req_middle_angle,
   input  logic [11:0] req_bend_angle,
   input  logic [11:0] req_rot_angle,
   output logic        rsp_valid,
   output logic [11:0] rsp_index_out,
   output logic [11:0] rsp_middle_out,
   output logic [11:0] rsp_bend_out,
   output logic [11:0] rsp_rot_out,
   output logic [4:0]  rsp_fix_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import ftci_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       map_busy, go;

   assign csr_ready = 1'b1;
   assign go = start && !busy;

   ftci_ctrl u_ctrl (.clock, .reset, .start(go), .req_mode, .map_busy, .status,
                     .cmd, .busy);

   ftci_dpath u_dpath (.clock, .reset, .cmd, .req_mode, .req_table_addr,
      .req_table_value, .req_index_target, .req_middle_target, .req_bend_target,
      .req_rot_target, .req_index_angle, .req_middle_angle, .req_bend_angle,
      .req_rot_angle, .csr_valid, .csr_index, .csr_data, .map_busy, .status,
      .rsp_valid, .rsp_index_out, .rsp_middle_out, .rsp_bend_out, .rsp_rot_out,
      .rsp_fix_count);

`ifndef SYNTHESIS
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("back to back results");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      go |=> busy) else $error("request not taken");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
`endif
endmodule

// ===== dv/tb_finger_thumb_collision_interlock_top.sv =====
// Self-checking testbench for the finger/thumb collision interlock top level.
`timescale 1ns / 100ps

module tb_finger_thumb_collision_interlock_top;
   import ftci_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int SCALE_MAX  = 2000;
   // Checks keep the lesser of index and middle below 896, so only the first
   // eight grid rows are ever read and only those are loaded up front.
   localparam int FILL_CELLS = 8 * GRID_SIDE;

   // One request as the sender sees it.
   typedef struct {
      logic [1:0]  mode;
      logic [7:0]  addr;
      logic [11:0] value;
      logic [15:0] tgt [4];
      logic [11:0] ang [4];
   } interlock_req_type;

   // One expected response.
   typedef struct {
      logic [11:0] index_out;
      logic [11:0] middle_out;
      logic [11:0] bend_out;
      logic [11:0] rot_out;
      logic [4:0]  fix_count;
   } interlock_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [7:0]  req_table_addr;
   logic [11:0] req_table_value;
   logic [15:0] req_index_target;
   logic [15:0] req_middle_target;
   logic [15:0] req_bend_target;
   logic [15:0] req_rot_target;
   logic [11:0] req_index_angle;
   logic [11:0] req_middle_angle;
   logic [11:0] req_bend_angle;
   logic [11:0] req_rot_angle;
   logic        rsp_valid;
   logic [11:0] rsp_index_out;
   logic [11:0] rsp_middle_out;
   logic [11:0] rsp_bend_out;
   logic [11:0] rsp_rot_out;
   logic [4:0]  rsp_fix_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [10:0] csr_data;

   finger_thumb_collision_interlock_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_table_addr(req_table_addr),
      .req_table_value(req_table_value), .req_index_target(req_index_target),
      .req_middle_target(req_middle_target), .req_bend_target(req_bend_target),
      .req_rot_target(req_rot_target), .req_index_angle(req_index_angle),
      .req_middle_angle(req_middle_angle), .req_bend_angle(req_bend_angle),
      .req_rot_angle(req_rot_angle), .rsp_valid(rsp_valid),
      .rsp_index_out(rsp_index_out), .rsp_middle_out(rsp_middle_out),
      .rsp_bend_out(rsp_bend_out), .rsp_rot_out(rsp_rot_out),
      .rsp_fix_count(rsp_fix_count), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the block's state.
   int bend_floor [TABLE_CELLS];
   int rot_floor [TABLE_CELLS];
   int clash_level;
   int block_level;
   int safe_level;

   interlock_rsp_type expected_rsp_q [$];
   int  mismatches;
   int  requests_sent;
   int  checks_sent;
   int  loads_sent;
   int  rsps_seen;
   int  csr_writes;
   int  max_fixes;
   int  idle_cycles;
   bit  gaps_on;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Target clamp: all ones means no command, other negatives clamp to zero.
   function automatic int clamp_cmd(input logic [15:0] t);
      if (t == 16'hFFFF) return -1;
      if (t[15]) return 0;
      if (t > SCALE_MAX) return SCALE_MAX;
      return int'(t);
   endfunction

   // Raw angle mapped onto the 0..2000 scale.
   function automatic int angle_scale(input logic [11:0] a);
      int t;
      if (a <= 890) return 0;
      t = (int'(a) - 890) * 2000 / 960;
      return (t > SCALE_MAX) ? SCALE_MAX : t;
   endfunction

   function automatic int grid_cell(input int v);
      int c;
      c = v / GRID_STEP;
      return (c > GRID_SIDE - 1) ? GRID_SIDE - 1 : c;
   endfunction

   // Largest floor among the four cells around the point, capped at full scale.
   function automatic int cell_floor(input bit bend_tab, input int row_v, input int col_v);
      int r0;
      int c0;
      int r1;
      int c1;
      int m;
      int v [4];
      r0 = grid_cell(row_v);
      c0 = grid_cell(col_v);
      r1 = (r0 + 1 < GRID_SIDE) ? r0 + 1 : r0;
      c1 = (c0 + 1 < GRID_SIDE) ? c0 + 1 : c0;
      if (bend_tab) begin
         v = '{bend_floor[r0*GRID_SIDE+c0], bend_floor[r0*GRID_SIDE+c1],
               bend_floor[r1*GRID_SIDE+c0], bend_floor[r1*GRID_SIDE+c1]};
      end else begin
         v = '{rot_floor[r0*GRID_SIDE+c0], rot_floor[r0*GRID_SIDE+c1],
               rot_floor[r1*GRID_SIDE+c0], rot_floor[r1*GRID_SIDE+c1]};
      end
      m = v[0];
      for (int i = 1; i < 4; i++) if (v[i] > m) m = v[i];
      return (m < SCALE_MAX) ? m : SCALE_MAX;
   endfunction

   // Apply one accepted request to the shadow state and work out its response.
   function automatic interlock_rsp_type predict_interlock(input interlock_req_type r);
      interlock_rsp_type e;
      int t [4];
      int a [4];
      int idx;
      int thb;
      int rot;
      int f;
      int want;
      int fixes;
      bit changed;
      fixes = 0;
      if (r.mode != MODE_CHECK) begin
         if (r.mode == MODE_BEND) bend_floor[r.addr] = r.value;
         else if (r.mode == MODE_ROT) rot_floor[r.addr] = r.value;
         e = '{NO_TARGET, NO_TARGET, NO_TARGET, NO_TARGET, 5'd0};
         return e;
      end
      for (int i = 0; i < 4; i++) begin
         t[i] = clamp_cmd(r.tgt[i]);
         a[i] = angle_scale(r.ang[i]);
      end
      // Scalar rules: clash of index and thumb bend, then rotation block.
      idx = (t[0] != -1) ? t[0] : a[0];
      thb = (t[2] != -1) ? t[2] : a[2];
      if (idx < clash_level && thb < clash_level) begin
         t[2] = clash_level;
         fixes++;
      end
      rot = (t[3] != -1) ? t[3] : a[3];
      if (idx < block_level && rot < safe_level) begin
         t[3] = safe_level;
         fixes++;
      end
      // Grid passes until nothing moves, at most MAX_PASSES of them.
      for (int p = 0; p < MAX_PASSES; p++) begin
         changed = 1'b0;
         f = (t[1] != -1) ? t[1] : a[1];
         if (idx < f) f = idx;
         thb = (t[2] != -1) ? t[2] : a[2];
         rot = (t[3] != -1) ? t[3] : a[3];
         want = cell_floor(1'b1, f, rot);
         if (thb < want) begin
            t[2] = want;
            thb = want;
            fixes++;
            changed = 1'b1;
         end
         want = cell_floor(1'b0, f, thb);
         if (rot < want) begin
            t[3] = want;
            fixes++;
            changed = 1'b1;
         end
         if (!changed) break;
      end
      if (fixes > 31) fixes = 31;
      if (fixes > max_fixes) max_fixes = fixes;
      e.index_out  = t[0][11:0];
      e.middle_out = t[1][11:0];
      e.bend_out   = t[2][11:0];
      e.rot_out    = t[3][11:0];
      e.fix_count  = fixes[4:0];
      return e;
   endfunction

   // Send one request, with an occasional idle gap first.
   task automatic send_request(input interlock_req_type r);
      if (gaps_on && $urandom_range(99) < 22) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start             <= 1'b1;
      req_mode          <= r.mode;
      req_table_addr    <= r.addr;
      req_table_value   <= r.value;
      req_index_target  <= r.tgt[0];
      req_middle_target <= r.tgt[1];
      req_bend_target   <= r.tgt[2];
      req_rot_target    <= r.tgt[3];
      req_index_angle   <= r.ang[0];
      req_middle_angle  <= r.ang[1];
      req_bend_angle    <= r.ang[2];
      req_rot_angle     <= r.ang[3];
      do @(posedge clock); while (busy);
      expected_rsp_q.push_back(predict_interlock(r));
      requests_sent++;
      if (r.mode == MODE_CHECK) checks_sent++;
      else loads_sent++;
   endtask

   // Stop sending and wait until every response is back.
   task automatic drain_responses();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write, only issued while the block is idle.
   task automatic write_register(input logic [1:0] idx, input logic [10:0] data);
      int v;
      drain_responses();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      v = (data > SCALE_MAX) ? SCALE_MAX : int'(data);
      case (idx)
         REG_CLASH: clash_level = v;
         REG_BLOCK: block_level = v;
         REG_SAFE:  safe_level = v;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_target();
      int k;
      k = $urandom_range(99);
      if (k < 25) return 16'hFFFF;
      if (k < 75) return 16'($urandom_range(0, 2000));
      if (k < 85) return 16'($urandom_range(2001, 32767));
      if (k < 92) return 16'($urandom_range(16'h8000, 16'hFFFE));
      return 16'($urandom);
   endfunction

   function automatic logic [11:0] rand_angle();
      if ($urandom_range(99) < 70) return 12'($urandom_range(850, 1900));
      return 12'($urandom);
   endfunction

   function automatic logic [11:0] rand_floor();
      int k;
      k = $urandom_range(99);
      if (k < 45) return 12'd0;
      if (k < 90) return 12'($urandom_range(0, 1400));
      if (k < 95) return 12'($urandom_range(1400, 2000));
      return 12'($urandom_range(2001, 2050));
   endfunction

   // Random check with index or middle held below 896, absent, low or negative.
   function automatic interlock_req_type rand_check();
      interlock_req_type r;
      int lo;
      int k;
      r.mode  = MODE_CHECK;
      r.addr  = 8'($urandom);
      r.value = 12'($urandom);
      for (int i = 0; i < 4; i++) begin
         r.tgt[i] = rand_target();
         r.ang[i] = rand_angle();
      end
      lo = $urandom_range(1);
      k  = $urandom_range(99);
      if (k < 40) begin
         r.tgt[lo] = 16'hFFFF;
         r.ang[lo] = 12'($urandom_range(0, 1319));
      end else if (k < 90) begin
         r.tgt[lo] = 16'($urandom_range(0, 895));
      end else begin
         r.tgt[lo] = 16'($urandom_range(16'h8000, 16'hFFFE));
      end
      return r;
   endfunction

   function automatic interlock_req_type load_req(input logic [1:0] m, input logic [7:0] a,
                                                  input logic [11:0] v);
      interlock_req_type r;
      r = rand_check();
      r.mode  = m;
      r.addr  = a;
      r.value = v;
      return r;
   endfunction

   // Every entry that a check can read is written before any check runs.
   task automatic test_table_fill();
      for (int i = 0; i < FILL_CELLS; i++) begin
         send_request(load_req(MODE_BEND, 8'(i), rand_floor()));
         send_request(load_req(MODE_ROT, 8'(i), rand_floor()));
      end
   endtask

   // Field extremes, unused mode, absent and out-of-range targets, capped floors.
   task automatic test_directed();
      interlock_req_type r;
      r = rand_check();
      r.tgt = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      r.ang = '{12'd0, 12'd0, 12'd0, 12'd0};
      send_request(r);
      r.ang = '{12'hFFF, 12'd0, 12'hFFF, 12'hFFF};
      send_request(r);
      r.ang = '{12'd890, 12'd891, 12'd1850, 12'd1851};
      send_request(r);
      r.tgt = '{16'd0, 16'd0, 16'd0, 16'd0};
      send_request(r);
      r.tgt = '{16'd2001, 16'd895, 16'h7FFF, 16'd1999};
      send_request(r);
      r.tgt = '{16'h8000, 16'hFFFE, 16'hFFFF, 16'h8000};
      send_request(r);
      r.tgt = '{16'd100, 16'd1500, 16'd100, 16'd100};
      send_request(r);
      // A far-column cell that marks nothing safe raises the thumb bend to full scale, where the rotation already is.
      send_request(load_req(MODE_BEND, 8'd127, 12'd2050));
      send_request(load_req(MODE_ROT, 8'd127, 12'd2050));
      r.tgt = '{16'd895, 16'd2000, 16'd0, 16'd2000};
      send_request(r);
      send_request(load_req(MODE_BEND, 8'd0, 12'd2000));
      send_request(load_req(MODE_ROT, 8'd0, 12'hFFF & 12'd1999));
      r.tgt = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF};
      send_request(r);
      // The unused mode changes nothing and answers with no targets.
      send_request(load_req(2'd3, 8'd0, 12'hFFF));
      send_request(r);
      send_request(load_req(MODE_BEND, 8'd0, 12'd0));
      send_request(load_req(MODE_ROT, 8'd0, 12'd0));
      send_request(load_req(MODE_BEND, 8'd127, 12'd0));
      send_request(load_req(MODE_ROT, 8'd127, 12'd0));
   endtask

   // Random mix: mostly checks, some table rewrites and the odd unused mode.
   task automatic test_random(input int count);
      int k;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         if (k < 10) send_request(load_req(MODE_BEND, 8'($urandom), rand_floor()));
         else if (k < 20) send_request(load_req(MODE_ROT, 8'($urandom), rand_floor()));
         else if (k < 23) send_request(load_req(2'd3, 8'($urandom), 12'($urandom)));
         else send_request(rand_check());
      end
   endtask

   // Register settings, from the extremes to random ones, with random traffic.
   task automatic test_register_sweep();
      logic [10:0] lv [4];
      lv = '{11'd0, 11'd2000, 11'h7FF, 11'd1000};
      for (int s = 0; s < 4; s++) begin
         write_register(REG_CLASH, lv[s]);
         write_register(REG_BLOCK, lv[(s + 1) % 4]);
         write_register(REG_SAFE, lv[(s + 2) % 4]);
         test_random(18);
      end
      for (int s = 0; s < 3; s++) begin
         write_register(REG_CLASH, 11'($urandom));
         write_register(REG_BLOCK, 11'($urandom_range(0, 2000)));
         write_register(REG_SAFE, 11'($urandom_range(0, 2000)));
         test_random(15);
      end
   endtask

   // Stall the sender until everything is back, then carry on.
   task automatic test_sender_pause();
      test_random(10);
      drain_responses();
      test_random(10);
   endtask

   // Response checker and stall watchdog.
   always @(posedge clock) begin
      interlock_rsp_type e;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
         if (rsp_valid) begin
            rsps_seen++;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response at %0t", $realtime);
            end else begin
               e = expected_rsp_q.pop_front();
               if (rsp_index_out !== e.index_out || rsp_middle_out !== e.middle_out ||
                   rsp_bend_out !== e.bend_out || rsp_rot_out !== e.rot_out ||
                   rsp_fix_count !== e.fix_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch #%0d: exp %h %h %h %h fix %0d, got %h %h %h %h fix %0d",
                              rsps_seen, e.index_out, e.middle_out, e.bend_out, e.rot_out,
                              e.fix_count, rsp_index_out, rsp_middle_out, rsp_bend_out,
                              rsp_rot_out, rsp_fix_count);
               end
            end
         end
      end
   end

   // Test sequence.
   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_CHECK;
      req_table_addr <= '0;
      req_table_value <= '0;
      req_index_target <= '0;
      req_middle_target <= '0;
      req_bend_target <= '0;
      req_rot_target <= '0;
      req_index_angle <= '0;
      req_middle_angle <= '0;
      req_bend_angle <= '0;
      req_rot_angle <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_CLASH;
      csr_data <= '0;
      clash_level = CLASH_RESET;
      block_level = BLOCK_RESET;
      safe_level = SAFE_RESET;
      mismatches = 0;
      requests_sent = 0;
      checks_sent = 0;
      loads_sent = 0;
      rsps_seen = 0;
      csr_writes = 0;
      max_fixes = 0;
      gaps_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_directed();
      // A stretch with back-to-back requests.
      gaps_on = 1'b0;
      test_random(30);
      gaps_on = 1'b1;
      test_sender_pause();
      test_register_sweep();
      test_random(10);

      drain_responses();
      repeat (150) @(posedge clock);
      $display("Covered %0d requests (%0d checks, %0d loads), %0d register writes,",
               requests_sent, checks_sent, loads_sent, csr_writes);
      $display("largest predicted correction count %0d, %0d mismatches",
               max_fixes, mismatches);
      if (mismatches == 0 && expected_rsp_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
